// ===== hw/rtl/frm_pkg.sv =====
// ----------------------------------------------------------------------------
// frm_pkg: shared types and constants of the fade ramp stereo mixer
// Configuration register indexes, stream widths, sequencer states and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package frm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;
  localparam int SMP_W      = 16;
  localparam int FRAME_NUM_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LEFT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_START     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_FRAMES = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT    = 3'd6;

  localparam logic [15:0] GAIN_RST          = 16'd16384;
  localparam logic [17:0] FADE_START_RST    = 18'd65536;
  localparam logic [17:0] FADE_STEP_RST     = 18'd0;
  localparam logic [5:0]  STEP_COUNT_RST    = 6'd0;
  localparam logic [10:0] SEGMENT_FRAMES_RST = 11'd1024;
  localparam logic [10:0] FRAME_COUNT_RST   = 11'd1024;

  localparam logic [17:0] FADE_MAX = 18'd131072;
  localparam logic signed [SMP_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [SMP_W-1:0] SAT_MIN = 16'sh8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FADE,
    ST_MUL1,
    ST_MUL2,
    ST_SCALE,
    ST_ACC,
    ST_DONE
  } frm_state_t;

  typedef struct packed {
    logic capture;
    logic fade;
    logic mul1;
    logic mul2;
    logic scale;
    logic acc;
    logic finish;
    logic load_out;
  } frm_cmd_t;

  typedef struct packed {
    logic last_voice;
  } frm_sts_t;

endpackage

// ===== hw/rtl/fade_ramp_stereo_mixer_top.sv =====
// ----------------------------------------------------------------------------
// fade_ramp_stereo_mixer_top: stereo voice mixer with per-segment fade ramp
// Scales each voice frame by gain and fade, accumulates it per frame and
// emits the saturated mix on the last voice.
// ----------------------------------------------------------------------------
// The sequencer walks each input item, from acceptance to completion,
// through fade computation, two multiply stages, scaling and a
// read-modify-write of the accumulator memory, one step a cycle, and
// takes the next item only when the previous one is complete. A completed
// mix is held in an output register, so the block goes on with the next
// item while that result waits; the final step waits only when a new result
// is due and the previous one has not yet been taken. The accumulator memory
// has no reset and needs no clearing pass: the first voice of a frame always
// overwrites its entry. Configuration must be written only while no item
// is in flight; the block itself does not enforce this.
module fade_ramp_stereo_mixer_top import frm_pkg::*; #(
  parameter int BUF_FRAMES = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // left_sample [15:0], right_sample [31:16]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // first_voice [0], last_voice [1]
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // mixed_left [15:0], mixed_right [31:16], frame_number [41:32], zero [47:42]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  frm_cmd_t cmd;
  frm_sts_t sts;

  frm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  frm_dp #(
    .BUF_FRAMES(BUF_FRAMES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_data  (s_axis_tdata),
    .in_user  (s_axis_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (m_axis_tdata),
    .out_last (m_axis_tlast)
  );

endmodule

// ===== hw/rtl/frm_ram.sv =====
// ----------------------------------------------------------------------------
// frm_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module frm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/frm_ctrl.sv =====
// ----------------------------------------------------------------------------
// frm_ctrl: sequencer of the fade ramp stereo mixer
// Steps one item at a time through the datapath and owns the input ready and
// the output valid flag.
// ----------------------------------------------------------------------------
module frm_ctrl import frm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  frm_sts_t sts,
  output frm_cmd_t cmd
);

  frm_state_t state;
  frm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_FADE;
        end
      end
      ST_FADE: begin
        cmd.fade   = 1'b1;
        state_next = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // A result may only be loaded once the previous one has been taken.
        if (!sts.last_voice || !out_valid || out_ready) begin
          cmd.finish   = 1'b1;
          cmd.load_out = sts.last_voice;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_item_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##6 state == ST_DONE)
    else $error("item did not reach the final step on time");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && sts.last_voice && out_valid && !out_ready |=> state == ST_DONE)
    else $error("sequencer left the final step while the output was stalled");

endmodule

// ===== hw/rtl/frm_dp.sv =====
// ----------------------------------------------------------------------------
// frm_dp: datapath of the fade ramp stereo mixer
// Configuration registers, frame and segment counters, fade computation,
// two-stage gain multiply, accumulator memory and the output register.
// ----------------------------------------------------------------------------
module frm_dp import frm_pkg::*; #(
  parameter int BUF_FRAMES = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic [1:0]            in_user,
  input  frm_cmd_t              cmd,
  output frm_sts_t              sts,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_last
);

  localparam int POS_W = $clog2(BUF_FRAMES);
  localparam int CNT_W = POS_W + 1;
  localparam int CMP_W = (CNT_W > 11) ? CNT_W : 11;

  logic [15:0]        gain_left;
  logic [15:0]        gain_right;
  logic [17:0]        fade_start;
  logic signed [17:0] fade_step;
  logic [5:0]         step_count;
  logic [10:0]        segment_frames;
  logic [10:0]        frame_count;

  logic [POS_W-1:0] frame_pos;
  logic [5:0]       segment_index;
  logic [POS_W-1:0] segment_pos;

  logic signed [15:0] smp_l;
  logic signed [15:0] smp_r;
  logic               first;
  logic               last;
  logic [POS_W-1:0]   pos;

  logic [17:0]        fade;
  logic [15:0]        mag_l;
  logic [15:0]        mag_r;
  logic               neg_l;
  logic               neg_r;
  logic [31:0]        p1_l;
  logic [31:0]        p1_r;
  logic [49:0]        p2_l;
  logic [49:0]        p2_r;
  logic signed [15:0] scaled_l;
  logic signed [15:0] scaled_r;
  logic signed [31:0] acc_l;
  logic signed [31:0] acc_r;

  logic signed [15:0] out_l;
  logic signed [15:0] out_r;
  logic [FRAME_NUM_W-1:0] out_fn;

  logic [5:0]         seg;
  logic signed [24:0] fade_prod;
  logic signed [25:0] fade_sum;
  logic [CMP_W-1:0]   fc_eff;
  logic [CMP_W-1:0]   pos_inc;
  logic [CMP_W-1:0]   seg_pos_inc;
  logic               eob;
  logic [63:0]        rd_data;
  logic [31:0]        sum_l;
  logic [31:0]        sum_r;

  function automatic logic signed [15:0] scale_sat(logic [19:0] r, logic neg);
    logic signed [15:0] res;
    if (neg) begin
      res = (r > 20'd32768) ? SAT_MIN : $signed(~r[15:0] + 16'd1);
    end else begin
      res = (r > 20'd32767) ? SAT_MAX : $signed(r[15:0]);
    end
    return res;
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [31:0] v);
    logic signed [15:0] res;
    if (v > 32'sd32767) begin
      res = SAT_MAX;
    end else if (v < -32'sd32768) begin
      res = SAT_MIN;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_left      <= GAIN_RST;
      gain_right     <= GAIN_RST;
      fade_start     <= FADE_START_RST;
      fade_step      <= $signed(FADE_STEP_RST);
      step_count     <= STEP_COUNT_RST;
      segment_frames <= SEGMENT_FRAMES_RST;
      frame_count    <= FRAME_COUNT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GAIN_LEFT:      gain_left      <= cfg_wdata[15:0];
        CFG_GAIN_RIGHT:     gain_right     <= cfg_wdata[15:0];
        CFG_FADE_START:     fade_start     <= cfg_wdata;
        CFG_FADE_STEP:      fade_step      <= $signed(cfg_wdata);
        CFG_STEP_COUNT:     step_count     <= cfg_wdata[5:0];
        CFG_SEGMENT_FRAMES: segment_frames <= cfg_wdata[10:0];
        CFG_FRAME_COUNT:    frame_count    <= cfg_wdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    seg       = (segment_frames == 11'd0) ? step_count : segment_index;
    fade_prod = $signed({1'b0, seg}) * fade_step;
    fade_sum  = $signed({8'd0, fade_start}) + 26'(fade_prod);
    if (frame_count == 11'd0) begin
      fc_eff = CMP_W'(1);
    end else if (CMP_W'(frame_count) > CMP_W'(BUF_FRAMES)) begin
      fc_eff = CMP_W'(BUF_FRAMES);
    end else begin
      fc_eff = CMP_W'(frame_count);
    end
    pos_inc     = CMP_W'(pos) + CMP_W'(1);
    seg_pos_inc = CMP_W'(segment_pos) + CMP_W'(1);
    eob         = pos_inc >= fc_eff;
    sum_l = first ? 32'(scaled_l) : rd_data[31:0] + 32'(scaled_l);
    sum_r = first ? 32'(scaled_r) : rd_data[63:32] + 32'(scaled_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp_l <= $signed(in_data[15:0]);
      smp_r <= $signed(in_data[31:16]);
      first <= in_user[0];
      last  <= in_user[1];
      pos   <= frame_pos;
    end
    if (cmd.fade) begin
      if (fade_sum[25]) begin
        fade <= 18'd0;
      end else if (fade_sum > $signed({8'd0, FADE_MAX})) begin
        fade <= FADE_MAX;
      end else begin
        fade <= fade_sum[17:0];
      end
      mag_l <= smp_l[15] ? (~smp_l + 16'd1) : smp_l;
      mag_r <= smp_r[15] ? (~smp_r + 16'd1) : smp_r;
      neg_l <= smp_l[15];
      neg_r <= smp_r[15];
    end
    if (cmd.mul1) begin
      p1_l <= mag_l * gain_left;
      p1_r <= mag_r * gain_right;
    end
    if (cmd.mul2) begin
      p2_l <= p1_l * fade;
      p2_r <= p1_r * fade;
    end
    if (cmd.scale) begin
      scaled_l <= scale_sat(p2_l[49:30], neg_l);
      scaled_r <= scale_sat(p2_r[49:30], neg_r);
    end
    if (cmd.acc) begin
      acc_l <= $signed(sum_l);
      acc_r <= $signed(sum_r);
    end
    if (cmd.load_out) begin
      out_l    <= sat16(acc_l);
      out_r    <= sat16(acc_r);
      out_fn   <= FRAME_NUM_W'(pos);
      out_last <= eob;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos     <= '0;
      segment_index <= '0;
      segment_pos   <= '0;
    end else if (cmd.finish) begin
      if (eob) begin
        frame_pos     <= '0;
        segment_index <= '0;
        segment_pos   <= '0;
      end else begin
        frame_pos <= POS_W'(pos_inc);
        if (segment_index < step_count && seg_pos_inc >= CMP_W'(segment_frames)) begin
          segment_index <= segment_index + 6'd1;
          segment_pos   <= '0;
        end else begin
          segment_pos <= POS_W'(seg_pos_inc);
        end
      end
    end
  end

  frm_ram #(
    .WIDTH(64),
    .DEPTH(BUF_FRAMES)
  ) u_acc_ram (
    .clk    (clk),
    .wr_en  (cmd.acc),
    .wr_addr(pos),
    .wr_data({sum_r, sum_l}),
    .rd_en  (cmd.capture),
    .rd_addr(frame_pos),
    .rd_data(rd_data)
  );

  assign sts.last_voice = last;
  assign out_data = {6'd0, out_fn, out_r, out_l};

  a_seg_behind_frame: assert property (@(posedge clk) disable iff (rst)
    segment_pos <= frame_pos)
    else $error("segment position ran ahead of the frame position");

  a_wrap_on_eob: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && eob |=> frame_pos == '0 && segment_index == 6'd0)
    else $error("counters not restarted at the end of the buffer");

  a_seg_single_step: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> segment_index == $past(segment_index) ||
                   segment_index == $past(segment_index) + 6'd1 ||
                   segment_index == 6'd0)
    else $error("segment index jumped");

endmodule
